### design/key_matrix_ghost_filter_unit_defines.svh
// Assertion macros shared by the ghost filter RTL.
`ifndef KEY_MATRIX_GHOST_FILTER_UNIT_DEFINES_SVH
`define KEY_MATRIX_GHOST_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KMGF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ghost filter assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define KMGF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ghost filter assertion failed");

`endif

### design/kmgf_pkg.sv
package kmgf_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int KEY_W    = 4;
  localparam int SIZE_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = CFG_IDX_W'(1);

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key_row;
    logic [KEY_W-1:0] key_col;
  } kmgf_req_t;

  typedef struct packed {
    logic forward;
    logic tracked;
  } kmgf_res_t;

  // Columns below the configured count.
  function automatic logic [MAX_COLS-1:0] col_mask(input logic [SIZE_W-1:0] cols);
    logic [MAX_COLS-1:0] m;
    for (int c = 0; c < MAX_COLS; c++) begin
      m[c] = (c < int'(cols));
    end
    return m;
  endfunction

  function automatic logic [MAX_COLS-1:0] col_onehot(input logic [KEY_W-1:0] col);
    logic [MAX_COLS-1:0] m;
    for (int c = 0; c < MAX_COLS; c++) begin
      m[c] = (int'(col) == c);
    end
    return m;
  endfunction

  // Zero counts as one, anything above the top counts as the top.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int top);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > top) begin
      r = SIZE_W'(top);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### design/kmgf_if.sv
interface kmgf_event_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [kmgf_pkg::KEY_W-1:0] key_row;
  logic [kmgf_pkg::KEY_W-1:0] key_col;

  modport source (output valid, output action, output key_row, output key_col,
                  input ready);
  modport sink   (input valid, input action, input key_row, input key_col,
                  output ready);
endinterface

interface kmgf_result_if;
  logic valid;
  logic ready;
  logic forward;
  logic tracked;

  modport source (output valid, output forward, output tracked, input ready);
  modport sink   (input valid, input forward, input tracked, output ready);
endinterface

### design/key_matrix_ghost_filter_unit.sv
// A result reaches the output register from the sequencer's done state: an event outside the
// configured area goes there straight from idle, a release after reading its own row, and a press
// after also scanning the configured rows. The next event is taken only once the result has left
// the sequencer; a press scans one stored row per cycle through the key map's single read port.
// Reset (synchronous, active high): no key held, both size registers at 16, no result.
`include "key_matrix_ghost_filter_unit_defines.svh"

module key_matrix_ghost_filter_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [kmgf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kmgf_pkg::SIZE_W-1:0]        cfg_data,
  kmgf_event_if.sink                         events,
  kmgf_result_if.source                      results
);

  // Size registers as written; clamping happens on the way into the sequencer.
  logic [kmgf_pkg::SIZE_W-1:0] rows_in_use;
  logic [kmgf_pkg::SIZE_W-1:0] cols_in_use;
  logic [kmgf_pkg::SIZE_W-1:0] rows_eff;
  logic [kmgf_pkg::SIZE_W-1:0] cols_eff;

  logic                start;
  logic                seq_idle;
  logic                seq_done;
  logic                res_take;
  kmgf_pkg::kmgf_req_t req;
  kmgf_pkg::kmgf_res_t seq_res;

  // Output register: it holds a finished result while the sink stalls.
  logic                out_valid;
  kmgf_pkg::kmgf_res_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= kmgf_pkg::SIZE_RESET;
      cols_in_use <= kmgf_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        kmgf_pkg::CFG_ROWS_IN_USE: rows_in_use <= cfg_data;
        kmgf_pkg::CFG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rows_eff = kmgf_pkg::clamp_size(rows_in_use, kmgf_pkg::MAX_ROWS);
  assign cols_eff = kmgf_pkg::clamp_size(cols_in_use, kmgf_pkg::MAX_COLS);

  // The sequencer takes a new beat only when it has returned to idle.
  assign events.ready = seq_idle;
  assign start        = events.valid & seq_idle;
  assign req.action   = events.action;
  assign req.key_row  = events.key_row;
  assign req.key_col  = events.key_col;

  kmgf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .rows_eff (rows_eff),
    .cols_eff (cols_eff),
    .res_take (res_take),
    .idle     (seq_idle),
    .done     (seq_done),
    .res      (seq_res)
  );

  // A finished result moves across when the output register is empty or is
  // being emptied in the same cycle.
  assign res_take = seq_done & (~out_valid | results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= seq_res;
    end
  end

  assign results.valid   = out_valid;
  assign results.forward = out_res.forward;
  assign results.tracked = out_res.tracked;

  // An accepted event always takes the sequencer out of idle in the next cycle.
  `KMGF_ASSERT_NXT(a_busy_after_accept, start, !events.ready)
  // Only a press can be blocked, and an untracked event is always passed on.
  `KMGF_ASSERT_IMP(a_untracked_forwarded, out_valid && !out_res.tracked, out_res.forward)
  // A finished result is never offered while the sequencer claims to be idle.
  `KMGF_ASSERT_IMP(a_done_not_idle, seq_done, !seq_idle)
  // A result handed over is visible at the output in the next cycle.
  `KMGF_ASSERT_NXT(a_take_loads_output, res_take, out_valid)

endmodule

### design/kmgf_row_check.sv
// Ghost test of one stored row against the row of the pressed switch.
module kmgf_row_check (
  input  logic [kmgf_pkg::MAX_COLS-1:0] row_bits,
  input  logic [kmgf_pkg::MAX_COLS-1:0] own_bits,
  input  logic [kmgf_pkg::MAX_COLS-1:0] others,
  input  logic [kmgf_pkg::MAX_COLS-1:0] col_bit,
  output logic                          hit
);

  logic [kmgf_pkg::MAX_COLS-1:0] m;
  logic                          held;

  always_comb begin
    m    = row_bits & others;
    held = |(row_bits & col_bit);
    // With the same column held in this row, one more corner anywhere is enough.
    hit  = held ? |(m | own_bits) : |(m & own_bits);
  end

endmodule

### design/kmgf_seq.sv
// Sequencer with the pressed-key map: reads the own row, then for a press one row a cycle.
module kmgf_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  kmgf_pkg::kmgf_req_t             req,
  input  logic [kmgf_pkg::SIZE_W-1:0]     rows_eff,
  input  logic [kmgf_pkg::SIZE_W-1:0]     cols_eff,
  input  logic                            res_take,
  output logic                            idle,
  output logic                            done,
  output kmgf_pkg::kmgf_res_t             res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OWN  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } kmgf_state_t;

  kmgf_state_t state;

  logic [kmgf_pkg::MAX_COLS-1:0] map_mem [kmgf_pkg::MAX_ROWS];
  logic [kmgf_pkg::MAX_ROWS-1:0] row_valid;
  logic [kmgf_pkg::ROW_W-1:0]    rd_addr;
  logic [kmgf_pkg::MAX_COLS-1:0] rd_bits;
  logic                          rd_ok;
  logic [kmgf_pkg::MAX_COLS-1:0] row_bits;

  logic                          act_q;
  logic [kmgf_pkg::ROW_W-1:0]    row_q;
  logic [kmgf_pkg::MAX_COLS-1:0] colbit_q;
  logic [kmgf_pkg::MAX_COLS-1:0] others_q;
  logic [kmgf_pkg::SIZE_W-1:0]   rows_q;
  logic [kmgf_pkg::MAX_COLS-1:0] own_q;
  logic [kmgf_pkg::ROW_W-1:0]    chk_row;
  logic                          ghost_q;
  logic                          ghost_next;
  logic                          hit;
  logic                          last_row;
  logic                          out_of_range;
  kmgf_pkg::kmgf_res_t           res_q;

  always_comb begin
    case (state)
      ST_IDLE: rd_addr = kmgf_pkg::ROW_W'(req.key_row);
      ST_OWN:  rd_addr = '0;
      ST_SCAN: rd_addr = kmgf_pkg::ROW_W'(chk_row + 1'b1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_bits <= map_mem[rd_addr];
    rd_ok   <= row_valid[rd_addr];
  end

  assign row_bits = rd_ok ? rd_bits : '0;

  kmgf_row_check u_check (
    .row_bits (row_bits),
    .own_bits (own_q & others_q),
    .others   (others_q),
    .col_bit  (colbit_q),
    .hit      (hit)
  );

  always_comb begin
    ghost_next   = ghost_q | (hit & (chk_row != row_q));
    last_row     = ({1'b0, chk_row} == kmgf_pkg::SIZE_W'(rows_q - 1'b1));
    out_of_range = ({1'b0, req.key_row} >= rows_eff) || ({1'b0, req.key_col} >= cols_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            act_q    <= req.action;
            row_q    <= kmgf_pkg::ROW_W'(req.key_row);
            colbit_q <= kmgf_pkg::col_onehot(req.key_col);
            others_q <= kmgf_pkg::col_mask(cols_eff) & ~kmgf_pkg::col_onehot(req.key_col);
            rows_q   <= rows_eff;
            if (out_of_range) begin
              res_q.forward <= 1'b1;
              res_q.tracked <= 1'b0;
              state         <= ST_DONE;
            end else begin
              state <= ST_OWN;
            end
          end
        end
        ST_OWN: begin
          own_q   <= row_bits;
          ghost_q <= 1'b0;
          chk_row <= '0;
          if (!act_q) begin
            map_mem[row_q]   <= row_bits & ~colbit_q;
            row_valid[row_q] <= 1'b1;
            res_q.forward    <= 1'b1;
            res_q.tracked    <= 1'b1;
            state            <= ST_DONE;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          ghost_q <= ghost_next;
          if (last_row) begin
            res_q.tracked <= 1'b1;
            if (ghost_next) begin
              res_q.forward <= 1'b0;
            end else begin
              map_mem[row_q]   <= own_q | colbit_q;
              row_valid[row_q] <= 1'b1;
              res_q.forward    <= 1'b1;
            end
            state <= ST_DONE;
          end else begin
            chk_row <= kmgf_pkg::ROW_W'(chk_row + 1'b1);
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE);
  assign res  = res_q;

endmodule

### tb/key_matrix_ghost_filter_unit_test.sv
module key_matrix_ghost_filter_unit_test;

  // The press-event bit of the input beat.
  localparam logic KEY_RELEASE = 1'b0;
  localparam logic KEY_PRESS   = 1'b1;

  // A press walks every stored row, so allow a full scan plus the output stage.
  localparam int SETTLE_CYCLES   = kmgf_pkg::MAX_ROWS + 4;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int PHASE_EVENTS    = 80;
  localparam int PHASE_COUNT     = 10;
  localparam int CYCLE_LIMIT     = 200000;

  typedef enum {STEP_KEY, STEP_SIZE} step_kind_t;

  // One row of the directed table: either a key beat or a size register write.
  // Rows with want_known set carry a verdict that can be read off by eye.
  typedef struct {
    step_kind_t                          kind;
    logic                                action;
    logic [kmgf_pkg::KEY_W-1:0]          row;
    logic [kmgf_pkg::KEY_W-1:0]          col;
    logic [kmgf_pkg::CFG_IDX_W-1:0]      reg_index;
    logic [kmgf_pkg::SIZE_W-1:0]         size;
    bit                                  want_known;
    kmgf_pkg::kmgf_res_t                 want;
  } directed_step_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_write;
  logic [kmgf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kmgf_pkg::SIZE_W-1:0]    cfg_data;

  kmgf_event_if  key_events ();
  kmgf_result_if key_verdicts ();

  key_matrix_ghost_filter_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (key_events),
    .results   (key_verdicts)
  );

  // Our own picture of the block: the held-switch map and both size registers.
  logic [kmgf_pkg::MAX_COLS-1:0] held_keys [kmgf_pkg::MAX_ROWS];
  logic [kmgf_pkg::SIZE_W-1:0]   rows_reg;
  logic [kmgf_pkg::SIZE_W-1:0]   cols_reg;

  // Verdicts owed by the block, oldest first.
  kmgf_pkg::kmgf_res_t pending_verdicts [$];
  directed_step_t directed_steps [$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;          // no idling on either side while set
  bit  hold_off_req = 1'b0;  // asks the verdict side for one long stall

  always #6 clk = ~clk;

  // Register values outside 1..top behave as the nearest end of that range.
  function automatic int span(input logic [kmgf_pkg::SIZE_W-1:0] v, input int top);
    int n;
    if (v == '0) begin
      n = 1;
    end else if (int'(v) > top) begin
      n = top;
    end else begin
      n = int'(v);
    end
    return n;
  endfunction

  // Works out the verdict for one key beat and updates the held-switch map.
  // A press is a ghost when, for some other row and other column, at least two
  // of the three remaining corners of the rectangle are already held. Only
  // rows and columns inside the configured area take part in that search.
  function automatic kmgf_pkg::kmgf_res_t judge_key_event(
      input logic action,
      input logic [kmgf_pkg::KEY_W-1:0] row,
      input logic [kmgf_pkg::KEY_W-1:0] col);
    kmgf_pkg::kmgf_res_t           verdict;
    int                            nrows;
    int                            ncols;
    logic [kmgf_pkg::MAX_COLS-1:0] own_bit;
    logic [kmgf_pkg::MAX_COLS-1:0] rivals;
    logic [kmgf_pkg::MAX_COLS-1:0] own_row;
    logic [kmgf_pkg::MAX_COLS-1:0] other_row;
    bit                            ghost;
    nrows = span(rows_reg, kmgf_pkg::MAX_ROWS);
    ncols = span(cols_reg, kmgf_pkg::MAX_COLS);
    verdict.forward = 1'b1;
    verdict.tracked = 1'b0;
    if (int'(row) < nrows && int'(col) < ncols) begin
      verdict.tracked = 1'b1;
      own_bit = '0;
      own_bit[col] = 1'b1;
      rivals = '0;
      for (int c = 0; c < ncols; c++) begin
        rivals[c] = 1'b1;
      end
      rivals = rivals & ~own_bit;
      if (action == KEY_PRESS) begin
        ghost = 1'b0;
        own_row = held_keys[row] & rivals;
        for (int r = 0; r < nrows; r++) begin
          if (r != int'(row)) begin
            other_row = held_keys[r] & rivals;
            if (held_keys[r][col]) begin
              // The corner in our column is held: any one more corner closes it.
              ghost = ghost | ((other_row | own_row) != '0);
            end else begin
              // Both remaining corners must share one column.
              ghost = ghost | ((other_row & own_row) != '0);
            end
          end
        end
        if (ghost) begin
          verdict.forward = 1'b0;
        end else begin
          held_keys[row][col] = 1'b1;
        end
      end else begin
        held_keys[row][col] = 1'b0;
      end
    end
    return verdict;
  endfunction

  function automatic directed_step_t key_step(input logic action,
                                              input int row, input int col);
    directed_step_t s;
    s = '{kind: STEP_KEY, action: action, row: kmgf_pkg::KEY_W'(row),
          col: kmgf_pkg::KEY_W'(col), reg_index: '0, size: '0, want_known: 1'b0,
          want: '0};
    return s;
  endfunction

  function automatic directed_step_t key_step_want(input logic action,
                                                   input int row, input int col,
                                                   input logic fwd, input logic trk);
    directed_step_t s;
    s = key_step(action, row, col);
    s.want_known = 1'b1;
    s.want.forward = fwd;
    s.want.tracked = trk;
    return s;
  endfunction

  function automatic directed_step_t size_step(
      input logic [kmgf_pkg::CFG_IDX_W-1:0] idx,
      input int value);
    directed_step_t s;
    s = '{kind: STEP_SIZE, action: KEY_RELEASE, row: '0, col: '0,
          reg_index: idx, size: kmgf_pkg::SIZE_W'(value), want_known: 1'b0,
          want: '0};
    return s;
  endfunction

  // Offers one key beat, with random idle cycles ahead of it unless calm is
  // set, and books the verdict once the block has taken the beat. The valid
  // line is left high afterwards so that beats can follow back to back.
  task automatic send_key_event(input logic action,
                                input logic [kmgf_pkg::KEY_W-1:0] row,
                                input logic [kmgf_pkg::KEY_W-1:0] col,
                                input bit want_known,
                                input kmgf_pkg::kmgf_res_t want);
    kmgf_pkg::kmgf_res_t verdict;
    while (!calm && $urandom_range(99) < 29) begin
      @(negedge clk);
      key_events.valid   <= 1'b0;
      key_events.action  <= 1'($urandom);
      key_events.key_row <= kmgf_pkg::KEY_W'($urandom);
      key_events.key_col <= kmgf_pkg::KEY_W'($urandom);
      @(posedge clk);
    end
    @(negedge clk);
    key_events.valid   <= 1'b1;
    key_events.action  <= action;
    key_events.key_row <= row;
    key_events.key_col <= col;
    do begin
      @(posedge clk);
    end while (!key_events.ready);
    verdict = judge_key_event(action, row, col);
    pending_verdicts.push_back(want_known ? want : verdict);
  endtask

  // Stops offering beats and waits until every owed verdict has come back,
  // then lets a full press scan's worth of cycles pass.
  task automatic drain_verdicts();
    @(negedge clk);
    key_events.valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [kmgf_pkg::CFG_IDX_W-1:0] idx,
                            input logic [kmgf_pkg::SIZE_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == kmgf_pkg::CFG_ROWS_IN_USE) begin
      rows_reg = value;
    end else begin
      cols_reg = value;
    end
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Random key beat. Most positions land inside the configured area so that
  // the map fills up and ghosts appear; a share of releases aim at a switch
  // that is actually held, which keeps the map from saturating.
  task automatic send_random_event();
    int   nrows;
    int   ncols;
    int   pick;
    int   held_row [$];
    int   held_col [$];
    logic action;
    logic [kmgf_pkg::KEY_W-1:0] row;
    logic [kmgf_pkg::KEY_W-1:0] col;
    nrows = span(rows_reg, kmgf_pkg::MAX_ROWS);
    ncols = span(cols_reg, kmgf_pkg::MAX_COLS);
    action = ($urandom_range(99) < 55) ? KEY_PRESS : KEY_RELEASE;
    if ($urandom_range(99) < 85) begin
      row = kmgf_pkg::KEY_W'($urandom_range(nrows - 1));
      col = kmgf_pkg::KEY_W'($urandom_range(ncols - 1));
    end else begin
      row = kmgf_pkg::KEY_W'($urandom);
      col = kmgf_pkg::KEY_W'($urandom);
    end
    if (action == KEY_RELEASE && $urandom_range(99) < 65) begin
      for (int r = 0; r < nrows; r++) begin
        for (int c = 0; c < ncols; c++) begin
          if (held_keys[r][c]) begin
            held_row.push_back(r);
            held_col.push_back(c);
          end
        end
      end
      if (held_row.size() != 0) begin
        pick = $urandom_range(held_row.size() - 1);
        row = kmgf_pkg::KEY_W'(held_row[pick]);
        col = kmgf_pkg::KEY_W'(held_col[pick]);
      end
    end
    send_key_event(action, row, col, 1'b0, '0);
  endtask

  // Verdict side: random stalls with a chance of about 29 in a hundred, none while
  // calm is set, and one long hold-off on request. The hold-off is counted
  // here so that the event side keeps pushing beats into a full block.
  initial begin : verdict_sink
    int stall_left;
    key_verdicts.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        key_verdicts.ready <= 1'b0;
      end else if (calm) begin
        key_verdicts.ready <= 1'b1;
      end else begin
        key_verdicts.ready <= ($urandom_range(99) >= 29);
      end
    end
  end

  // Every verdict beat is held against the oldest owed verdict.
  always @(posedge clk) begin
    if (!rst && key_verdicts.valid && key_verdicts.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict beat with no verdict owed: forward %0b tracked %0b",
               key_verdicts.forward, key_verdicts.tracked);
        error_count++;
      end else begin
        kmgf_pkg::kmgf_res_t owed;
        owed = pending_verdicts.pop_front();
        if (key_verdicts.forward !== owed.forward) begin
          $error("forward: expected %0b, got %0b", owed.forward, key_verdicts.forward);
          error_count++;
        end
        if (key_verdicts.tracked !== owed.tracked) begin
          $error("tracked: expected %0b, got %0b", owed.tracked, key_verdicts.tracked);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** key_matrix_ghost_filter_unit: FAILED **");
      $finish;
    end
  end

  initial begin : event_source
    logic [kmgf_pkg::SIZE_W-1:0] phase_rows [PHASE_COUNT];
    logic [kmgf_pkg::SIZE_W-1:0] phase_cols [PHASE_COUNT];
    directed_step_t              s;

    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    key_events.valid   = 1'b0;
    key_events.action  = KEY_RELEASE;
    key_events.key_row = '0;
    key_events.key_col = '0;
    for (int r = 0; r < kmgf_pkg::MAX_ROWS; r++) begin
      held_keys[r] = '0;
    end
    rows_reg = kmgf_pkg::SIZE_RESET;
    cols_reg = kmgf_pkg::SIZE_RESET;

    // Directed table, starting from the reset size of 16 by 16. The first
    // block builds an L of held switches and then probes both the "two held
    // corners in one line" and the "diagonal pair" ghost shapes.
    directed_steps.push_back(key_step_want(KEY_PRESS, 0, 0, 1'b1, 1'b1));
    directed_steps.push_back(key_step(KEY_PRESS, 0, 0));      // already held
    directed_steps.push_back(key_step(KEY_PRESS, 0, 15));
    directed_steps.push_back(key_step(KEY_PRESS, 15, 0));     // ghost
    directed_steps.push_back(key_step(KEY_PRESS, 15, 15));    // ghost
    directed_steps.push_back(key_step_want(KEY_RELEASE, 0, 15, 1'b1, 1'b1));
    directed_steps.push_back(key_step(KEY_PRESS, 15, 0));
    directed_steps.push_back(key_step(KEY_PRESS, 15, 15));    // diagonal ghost
    directed_steps.push_back(key_step(KEY_PRESS, 8, 8));
    directed_steps.push_back(key_step(KEY_PRESS, 8, 0));
    directed_steps.push_back(key_step_want(KEY_RELEASE, 5, 5, 1'b1, 1'b1)); // not held
    directed_steps.push_back(key_step_want(KEY_RELEASE, 15, 0, 1'b1, 1'b1));
    // Shrink the area: switches outside it pass through untracked, and the
    // switch at row 8, column 8 stays held but is left out of the search.
    directed_steps.push_back(size_step(kmgf_pkg::CFG_ROWS_IN_USE, 3));
    directed_steps.push_back(size_step(kmgf_pkg::CFG_COLS_IN_USE, 4));
    directed_steps.push_back(key_step_want(KEY_PRESS, 3, 0, 1'b1, 1'b0));
    directed_steps.push_back(key_step_want(KEY_PRESS, 0, 4, 1'b1, 1'b0));
    directed_steps.push_back(key_step_want(KEY_PRESS, 15, 15, 1'b1, 1'b0));
    directed_steps.push_back(key_step(KEY_PRESS, 2, 3));
    directed_steps.push_back(key_step_want(KEY_RELEASE, 8, 8, 1'b1, 1'b0));
    // A size of zero counts as one.
    directed_steps.push_back(size_step(kmgf_pkg::CFG_ROWS_IN_USE, 0));
    directed_steps.push_back(size_step(kmgf_pkg::CFG_COLS_IN_USE, 0));
    directed_steps.push_back(key_step_want(KEY_PRESS, 0, 0, 1'b1, 1'b1));
    directed_steps.push_back(key_step_want(KEY_PRESS, 0, 1, 1'b1, 1'b0));
    directed_steps.push_back(key_step_want(KEY_RELEASE, 1, 0, 1'b1, 1'b0));
    // All-ones sizes count as the full matrix; the kept switch comes back.
    directed_steps.push_back(size_step(kmgf_pkg::CFG_ROWS_IN_USE, 31));
    directed_steps.push_back(size_step(kmgf_pkg::CFG_COLS_IN_USE, 31));
    directed_steps.push_back(key_step(KEY_PRESS, 8, 0));      // ghost via (8,8)
    directed_steps.push_back(key_step_want(KEY_RELEASE, 8, 8, 1'b1, 1'b1));
    directed_steps.push_back(key_step(KEY_PRESS, 8, 0));
    directed_steps.push_back(key_step_want(KEY_RELEASE, 0, 0, 1'b1, 1'b1));

    // Sizes for the random phases: the full matrix, the extremes on both
    // registers, thin strips, a few small dense areas and two picked at random.
    phase_rows = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd16, 5'd2, 5'd3, 5'd16, 5'd0, 5'd0};
    phase_cols = '{5'd16, 5'd31, 5'd0, 5'd16, 5'd1, 5'd2, 5'd5, 5'd16, 5'd0, 5'd0};
    phase_rows[8] = kmgf_pkg::SIZE_W'($urandom_range(31));
    phase_cols[8] = kmgf_pkg::SIZE_W'($urandom_range(31));
    phase_rows[9] = kmgf_pkg::SIZE_W'($urandom_range(31));
    phase_cols[9] = kmgf_pkg::SIZE_W'($urandom_range(31));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.kind == STEP_SIZE) begin
        drain_verdicts();
        write_size(s.reg_index, s.size);
      end else begin
        send_key_event(s.action, s.row, s.col, s.want_known, s.want);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_verdicts();
      write_size(kmgf_pkg::CFG_ROWS_IN_USE, phase_rows[p]);
      write_size(kmgf_pkg::CFG_COLS_IN_USE, phase_cols[p]);
      // The first phase runs flat out on both sides; the second starts with
      // the verdict side held off so that the block backs up into its input.
      calm = (p == 0);
      if (p == 1) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        // Halfway through one phase, stop and let the block empty completely.
        if (p == 4 && n == PHASE_EVENTS / 2) begin
          drain_verdicts();
        end
        send_random_event();
      end
    end
    calm = 1'b0;

    drain_verdicts();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdicts never arrived", pending_verdicts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** key_matrix_ghost_filter_unit: PASSED **");
    end else begin
      $display("** key_matrix_ghost_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule

### key_matrix_ghost_filter_unit.f
+incdir+design
design/kmgf_pkg.sv
design/kmgf_if.sv
design/kmgf_row_check.sv
design/kmgf_seq.sv
design/key_matrix_ghost_filter_unit.sv
tb/key_matrix_ghost_filter_unit_test.sv
